// ----- rtl/core/dqv_pkg.sv -----
// Types and constants shared by the DNS query validator modules.
package dqv_pkg;

    localparam logic [3:0] HDR_LAST_INDEX = 4'd11;

    localparam logic [3:0] ST_OK         = 4'd0;
    localparam logic [3:0] ST_SHORT      = 4'd1;
    localparam logic [3:0] ST_RESPONSE   = 4'd2;
    localparam logic [3:0] ST_MULTI_Q    = 4'd3;
    localparam logic [3:0] ST_NO_Q       = 4'd4;
    localparam logic [3:0] ST_OPCODE     = 4'd5;
    localparam logic [3:0] ST_TRUNCATED  = 4'd6;
    localparam logic [3:0] ST_INCOMPLETE = 4'd7;
    localparam logic [3:0] ST_NAME_LONG  = 4'd8;
    localparam logic [3:0] ST_TYPE_CLASS = 4'd9;

    localparam logic [1:0] CFG_MAX_NAME_LEN   = 2'd0;
    localparam logic [1:0] CFG_ACCEPTED_TYPE  = 2'd1;
    localparam logic [1:0] CFG_ACCEPTED_CLASS = 2'd2;

    localparam logic [15:0] FLAGS_SET   = 16'h8080;
    localparam logic [15:0] FLAGS_CLEAR = 16'h067F;

    typedef enum logic [4:0] {
        PH_HEADER = 5'b00001,
        PH_NAME   = 5'b00010,
        PH_VALUES = 5'b00100,
        PH_ACCEPT = 5'b01000,
        PH_REJECT = 5'b10000
    } phase_t;

    typedef struct packed {
        logic [15:0] accepted_class;
        logic [15:0] accepted_type;
        logic [7:0]  max_name_len;
    } dqv_cfg_t;

    typedef struct packed {
        logic [15:0] question_class;
        logic [15:0] question_type;
        logic [7:0]  name_length;
        logic [15:0] reply_flags;
        logic [15:0] query_id;
        logic [3:0]  status;
    } dqv_result_t;

endpackage

// ----- rtl/core/dns_query_validator_unit.sv -----
// Top level of the DNS query validator: configuration, parser and result register.
// The slave stream carries one request byte per transfer, with s_tlast on the
// final byte of the datagram. The block checks the 12-byte header, walks the
// question name and compares type and class with the configured values.
// Exactly one verdict leaves on the master stream for every byte that carries
// s_tlast; no other byte produces output.
// A byte is taken in every cycle in which s_tvalid is high and the result
// register is empty or being emptied, so the sustained rate is one byte per
// clock. The verdict appears on m_tvalid in the cycle after the last byte is
// taken. The result register is the only storage between the two sides: while
// a verdict waits for m_tready, s_tready is low and no byte is taken.
// Configuration is written through cfg_we, cfg_index and cfg_data while no
// datagram is in flight; index 0 is the name length limit, 1 the accepted type
// and 2 the accepted class, and other indexes are ignored.
// Reset clears the parser to the start of a datagram, empties the result
// register and loads a limit of 255, type 1 and class 1.
module dns_query_validator_unit
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // packet_byte[7:0]
    input  logic        s_tlast,   // last_byte
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [79:0] m_tdata,   // status[3:0], query_id[19:4], reply_flags[35:20],
                                   // name_length[43:36], question_type[59:44],
                                   // question_class[75:60], zero[79:76]
    input  logic        cfg_we,
    input  logic [1:0]  cfg_index,
    input  logic [15:0] cfg_data
);

    dqv_pkg::dqv_cfg_t    cfg_reg;
    dqv_pkg::dqv_result_t result;
    dqv_pkg::dqv_result_t out_data_reg;
    logic                 out_valid_reg;
    logic                 byte_take;

    assign s_tready  = !out_valid_reg || m_tready;
    assign byte_take = s_tvalid && s_tready;
    assign m_tvalid  = out_valid_reg;
    assign m_tdata   = {4'd0, out_data_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.max_name_len   <= 8'd255;
            cfg_reg.accepted_type  <= 16'd1;
            cfg_reg.accepted_class <= 16'd1;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                dqv_pkg::CFG_MAX_NAME_LEN:   cfg_reg.max_name_len   <= cfg_data[7:0];
                dqv_pkg::CFG_ACCEPTED_TYPE:  cfg_reg.accepted_type  <= cfg_data;
                dqv_pkg::CFG_ACCEPTED_CLASS: cfg_reg.accepted_class <= cfg_data;
                default:
                begin
                end
            endcase
        end
    end

    dqv_parser u_parser
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .byte_take   (byte_take),
        .packet_byte (s_tdata),
        .last_byte   (s_tlast),
        .cfg         (cfg_reg),
        .result      (result)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (byte_take && s_tlast)
            out_valid_reg <= 1'b1;
        else if (m_tready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (byte_take && s_tlast)
            out_data_reg <= result;
    end

    a_last_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
        (s_tvalid && s_tready && s_tlast) |=> m_tvalid)
        else $error("last byte taken without a verdict");

    a_middle_no_result: assert property (@(posedge clk) disable iff (!rst_n)
        (!m_tvalid && !(s_tvalid && s_tready && s_tlast)) |=> !m_tvalid)
        else $error("verdict without a last byte");

    a_status_range: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (m_tdata[3:0] <= dqv_pkg::ST_TYPE_CLASS))
        else $error("status code out of range");

    a_short_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tdata[3:0] == dqv_pkg::ST_SHORT) |-> (m_tdata[75:4] == 72'd0))
        else $error("short header verdict carries data");

    a_name_len_ok_only: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tdata[3:0] != dqv_pkg::ST_OK) |-> (m_tdata[43:36] == 8'd0))
        else $error("name length given on a rejected request");

endmodule

// ----- rtl/core/dqv_parser.sv -----
// Per-byte parser state and verdict logic of the DNS query validator.
module dqv_parser
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 byte_take,
    input  logic [7:0]           packet_byte,
    input  logic                 last_byte,
    input  dqv_pkg::dqv_cfg_t    cfg,
    output dqv_pkg::dqv_result_t result
);

    dqv_pkg::phase_t phase_reg, phase_next;
    logic [3:0]  header_index_reg, header_index_next;
    logic [15:0] held_id_reg, held_id_next;
    logic [15:0] request_flags_reg, request_flags_next;
    logic [15:0] question_count_reg, question_count_next;
    logic [8:0]  name_bytes_reg, name_bytes_next;
    logic [7:0]  label_left_reg, label_left_next;
    logic [1:0]  value_index_reg, value_index_next;
    logic [31:0] type_class_reg, type_class_next;
    logic [3:0]  status_held_reg, status_held_next;
    logic [3:0]  verdict;
    logic [3:0]  st;

    function automatic logic [3:0] header_verdict(input logic [15:0] flags,
                                                  input logic [15:0] qcount);
        logic [3:0] v;
        begin
            if (flags[15])
                v = dqv_pkg::ST_RESPONSE;
            else if (qcount > 16'd1)
                v = dqv_pkg::ST_MULTI_Q;
            else if (qcount == 16'd0)
                v = dqv_pkg::ST_NO_Q;
            else if (flags[14:11] != 4'd0)
                v = dqv_pkg::ST_OPCODE;
            else if (flags[9])
                v = dqv_pkg::ST_TRUNCATED;
            else
                v = dqv_pkg::ST_OK;
            return v;
        end
    endfunction

    always_comb
    begin
        phase_next          = phase_reg;
        header_index_next   = header_index_reg;
        held_id_next        = held_id_reg;
        request_flags_next  = request_flags_reg;
        question_count_next = question_count_reg;
        name_bytes_next     = name_bytes_reg;
        label_left_next     = label_left_reg;
        value_index_next    = value_index_reg;
        type_class_next     = type_class_reg;
        status_held_next    = status_held_reg;
        verdict             = dqv_pkg::ST_OK;
        case (phase_reg)
            dqv_pkg::PH_HEADER:
            begin
                if (header_index_reg < 4'd2)
                    held_id_next = {held_id_reg[7:0], packet_byte};
                else if (header_index_reg < 4'd4)
                    request_flags_next = {request_flags_reg[7:0], packet_byte};
                else if (header_index_reg < 4'd6)
                    question_count_next = {question_count_reg[7:0], packet_byte};
                if (header_index_reg >= dqv_pkg::HDR_LAST_INDEX)
                begin
                    verdict = header_verdict(request_flags_reg, question_count_reg);
                    if (verdict != dqv_pkg::ST_OK)
                    begin
                        status_held_next = verdict;
                        phase_next       = dqv_pkg::PH_REJECT;
                    end
                    else
                    begin
                        phase_next = dqv_pkg::PH_NAME;
                    end
                end
                else
                begin
                    header_index_next = header_index_reg + 4'd1;
                end
            end
            dqv_pkg::PH_NAME:
            begin
                if (name_bytes_reg != 9'd511)
                    name_bytes_next = name_bytes_reg + 9'd1;
                if (label_left_reg != 8'd0)
                    label_left_next = label_left_reg - 8'd1;
                else if (packet_byte != 8'd0)
                    label_left_next = packet_byte;
                else if (name_bytes_next > {1'b0, cfg.max_name_len})
                begin
                    status_held_next = dqv_pkg::ST_NAME_LONG;
                    phase_next       = dqv_pkg::PH_REJECT;
                end
                else
                begin
                    phase_next = dqv_pkg::PH_VALUES;
                end
            end
            dqv_pkg::PH_VALUES:
            begin
                type_class_next = {type_class_reg[23:0], packet_byte};
                if (value_index_reg == 2'd3)
                begin
                    if (type_class_next[31:16] != cfg.accepted_type ||
                        type_class_next[15:0] != cfg.accepted_class)
                    begin
                        status_held_next = dqv_pkg::ST_TYPE_CLASS;
                        phase_next       = dqv_pkg::PH_REJECT;
                    end
                    else
                    begin
                        phase_next = dqv_pkg::PH_ACCEPT;
                    end
                end
                else
                begin
                    value_index_next = value_index_reg + 2'd1;
                end
            end
            default:
            begin
            end
        endcase
    end

    always_comb
    begin
        case (phase_next)
            dqv_pkg::PH_HEADER: st = dqv_pkg::ST_SHORT;
            dqv_pkg::PH_NAME:   st = dqv_pkg::ST_INCOMPLETE;
            dqv_pkg::PH_VALUES: st = dqv_pkg::ST_INCOMPLETE;
            dqv_pkg::PH_ACCEPT: st = dqv_pkg::ST_OK;
            default:            st = status_held_next;
        endcase
        result.status = st;
        result.query_id = (st == dqv_pkg::ST_SHORT) ? 16'd0 : held_id_next;
        result.reply_flags = (st == dqv_pkg::ST_SHORT) ? 16'd0 :
            ((request_flags_next | dqv_pkg::FLAGS_SET) & ~dqv_pkg::FLAGS_CLEAR);
        result.name_length = (st == dqv_pkg::ST_OK) ? name_bytes_next[7:0] : 8'd0;
        if (st == dqv_pkg::ST_OK || st == dqv_pkg::ST_TYPE_CLASS)
        begin
            result.question_type  = type_class_next[31:16];
            result.question_class = type_class_next[15:0];
        end
        else
        begin
            result.question_type  = 16'd0;
            result.question_class = 16'd0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg          <= dqv_pkg::PH_HEADER;
            header_index_reg   <= 4'd0;
            held_id_reg        <= 16'd0;
            request_flags_reg  <= 16'd0;
            question_count_reg <= 16'd0;
            name_bytes_reg     <= 9'd0;
            label_left_reg     <= 8'd0;
            value_index_reg    <= 2'd0;
            type_class_reg     <= 32'd0;
            status_held_reg    <= 4'd0;
        end
        else if (byte_take)
        begin
            if (last_byte)
            begin
                phase_reg          <= dqv_pkg::PH_HEADER;
                header_index_reg   <= 4'd0;
                held_id_reg        <= 16'd0;
                request_flags_reg  <= 16'd0;
                question_count_reg <= 16'd0;
                name_bytes_reg     <= 9'd0;
                label_left_reg     <= 8'd0;
                value_index_reg    <= 2'd0;
                type_class_reg     <= 32'd0;
                status_held_reg    <= 4'd0;
            end
            else
            begin
                phase_reg          <= phase_next;
                header_index_reg   <= header_index_next;
                held_id_reg        <= held_id_next;
                request_flags_reg  <= request_flags_next;
                question_count_reg <= question_count_next;
                name_bytes_reg     <= name_bytes_next;
                label_left_reg     <= label_left_next;
                value_index_reg    <= value_index_next;
                type_class_reg     <= type_class_next;
                status_held_reg    <= status_held_next;
            end
        end
    end

endmodule
